### rtl/lbvh_pkg.sv
package lbvh_pkg;

	localparam int MAX_PRIM   = 1024;
	localparam int PRIM_W     = 10;
	localparam int NODE_W     = 11;
	localparam int NODE_DEPTH = 2 ** NODE_W;
	localparam int MORTON_W   = 32;
	localparam int KEY_W      = MORTON_W + PRIM_W;

	typedef logic [PRIM_W-1:0] prim_idx_t;
	typedef logic [NODE_W-1:0] node_idx_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic signed [7:0] delta_t;

	localparam node_idx_t         NO_CHILD    = 11'd2047;
	localparam logic [NODE_W-1:0] NOT_LEAF    = 11'd1024;
	localparam logic signed [31:0] COORD_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COORD_MIN  = 32'sh8000_0000;
	localparam delta_t            DELTA_EDGE  = -8'sd1;
	localparam delta_t            DELTA_EQUAL = 8'sd64;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
	} box_t;

	typedef struct packed {
		prim_idx_t first;
		prim_idx_t last;
		node_idx_t left;
		node_idx_t right;
		prim_idx_t leaf;
		logic      visited;
		box_t      box;
	} node_t;

	typedef struct packed {
		logic first;
		logic last;
		logic left;
		logic right;
		logic leaf;
		logic visited;
		logic box;
	} node_we_t;

endpackage

### rtl/lbvh_bottom_up_builder_core.sv
// Loads are taken one per cycle while idle; S_READ registers a read's word.
// The last load starts the build: an insertion sort over the key memory, a delta pass
// over the leaves, a node init of the internal nodes, then a climb from each leaf that
// merges through every parent it finds already visited.
// No item is taken during a build or while a result word waits. Reset clears the load count,
// the built count, the root and the handshakes; no tree exists.
module lbvh_bottom_up_builder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [31:0]         morton_code,
	input  logic signed [31:0]  box_min_x,
	input  logic signed [31:0]  box_min_y,
	input  logic signed [31:0]  box_min_z,
	input  logic signed [31:0]  box_max_x,
	input  logic signed [31:0]  box_max_y,
	input  logic signed [31:0]  box_max_z,
	input  logic                final_primitive,
	input  logic [10:0]         node_to_read,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [9:0]          span_first,
	output logic [9:0]          span_final,
	output logic [10:0]         left_link,
	output logic [10:0]         right_link,
	output logic [10:0]         leaf_primitive,
	output logic signed [31:0]  merged_min_x,
	output logic signed [31:0]  merged_min_y,
	output logic signed [31:0]  merged_min_z,
	output logic signed [31:0]  merged_max_x,
	output logic signed [31:0]  merged_max_y,
	output logic signed [31:0]  merged_max_z,
	output logic [10:0]         root_node
);
	import lbvh_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SORT_FETCH, S_SORT_KEY, S_SORT_CMP, S_SORT_PLACE,
		S_DLT_RD, S_DLT_X, S_DLT_WR, S_DLT_END, S_INIT,
		S_CLB_LEAF, S_CLB_BOX, S_CLB_DRD, S_CLB_PAR, S_CLB_UPD
	} state_t;

	state_t    state_q;
	logic [10:0] count_q, n_q, built_q, i_q, j_q;
	node_idx_t root_q, node_q, par_q, rd_idx_q;
	key_t      k_q, prev_q, kd_q;
	prim_idx_t s_q, e_q;
	box_t      box_q;
	logic      lt_q;
	logic      out_valid_q;
	node_t     out_q;
	logic [10:0] leaf_out_q;
	node_idx_t root_out_q;

	key_t      key_mem [MAX_PRIM];
	box_t      lbox_mem [MAX_PRIM];
	delta_t    delta_mem [MAX_PRIM + 1];

	logic      key_we;
	prim_idx_t key_wa, key_ra;
	key_t      key_wd, key_rd;
	logic      lbox_we;
	box_t      lbox_wd, lbox_rd;
	logic      d_we;
	logic [10:0] d_wa, d_ra0, d_ra1;
	delta_t    d_wd, d_rd0, d_rd1, delta_s1;
	node_we_t  n_we;
	node_idx_t n_wa, n_ra;
	node_t     n_wd, node_rd;

	logic      accept, lt, brk;
	node_idx_t par;
	box_t      merged;
	prim_idx_t new_first, new_last;
	logic [11:0] node_count, built_nodes;

	assign accept = in_valid & in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign node_count = {n_q, 1'b0} - 12'd1;
	assign built_nodes = {built_q, 1'b0} - 12'd1;

	lbvh_delta_unit u_delta (
		.clk      (clk),
		.diff     (prev_q ^ key_rd),
		.delta_s1 (delta_s1)
	);

	lbvh_node_mem u_nodes (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_wa),
		.wdata (n_wd),
		.raddr (n_ra),
		.rdata (node_rd)
	);

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd <= key_mem[key_ra];
		if (lbox_we) lbox_mem[count_q[PRIM_W-1:0]] <= lbox_wd;
		lbox_rd <= lbox_mem[key_rd[PRIM_W-1:0]];
		if (d_we) delta_mem[d_wa] <= d_wd;
		d_rd0 <= delta_mem[d_ra0];
		d_rd1 <= delta_mem[d_ra1];
	end

	always_comb begin
		lt = d_rd0 < d_rd1;
		if (lt) begin
			par = node_idx_t'({1'b0, e_q}) + n_q;
			brk = ({1'b0, e_q} == n_q - 11'd1);
		end else begin
			par = node_idx_t'({1'b0, s_q}) - 11'd1 + n_q;
			brk = (s_q == '0);
		end
		merged.min_x = (box_q.min_x < node_rd.box.min_x) ? box_q.min_x : node_rd.box.min_x;
		merged.min_y = (box_q.min_y < node_rd.box.min_y) ? box_q.min_y : node_rd.box.min_y;
		merged.min_z = (box_q.min_z < node_rd.box.min_z) ? box_q.min_z : node_rd.box.min_z;
		merged.max_x = (box_q.max_x > node_rd.box.max_x) ? box_q.max_x : node_rd.box.max_x;
		merged.max_y = (box_q.max_y > node_rd.box.max_y) ? box_q.max_y : node_rd.box.max_y;
		merged.max_z = (box_q.max_z > node_rd.box.max_z) ? box_q.max_z : node_rd.box.max_z;
		new_first = lt_q ? s_q : node_rd.first;
		new_last = lt_q ? node_rd.last : e_q;
	end

	always_comb begin
		key_we = 1'b0;
		key_wa = count_q[PRIM_W-1:0];
		key_wd = {morton_code, count_q[PRIM_W-1:0]};
		key_ra = i_q[PRIM_W-1:0];
		lbox_we = 1'b0;
		lbox_wd = '{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z};
		d_we = 1'b0;
		d_wa = i_q;
		d_wd = (i_q == '0) ? DELTA_EDGE : delta_s1;
		d_ra0 = {1'b0, s_q};
		d_ra1 = {1'b0, e_q} + 11'd1;
		n_we = '0;
		n_wa = i_q;
		n_wd.first = i_q[PRIM_W-1:0];
		n_wd.last = i_q[PRIM_W-1:0];
		n_wd.left = NO_CHILD;
		n_wd.right = NO_CHILD;
		n_wd.leaf = kd_q[PRIM_W-1:0];
		n_wd.visited = 1'b0;
		n_wd.box = lbox_rd;
		n_ra = i_q;
		case (state_q)
			S_IDLE: begin
				n_ra = node_to_read;
				if (accept && action == ACT_LOAD && count_q < 11'(MAX_PRIM)) begin
					key_we = 1'b1;
					lbox_we = 1'b1;
				end
			end
			S_SORT_KEY: key_ra = i_q[PRIM_W-1:0] - 10'd1;
			S_SORT_CMP: begin
				key_we = 1'b1;
				key_wa = j_q[PRIM_W-1:0];
				key_wd = (key_rd > k_q) ? key_rd : k_q;
				key_ra = j_q[PRIM_W-1:0] - 10'd2;
			end
			S_SORT_PLACE: begin
				key_we = 1'b1;
				key_wa = '0;
				key_wd = k_q;
			end
			S_DLT_WR: begin
				d_we = 1'b1;
				n_we = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
			end
			S_DLT_END: begin
				d_we = 1'b1;
				d_wa = n_q;
				d_wd = DELTA_EDGE;
			end
			S_INIT: begin
				if ({1'b0, i_q} < node_count) begin
					n_we = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
				end
				n_wd.first = '0;
				n_wd.last = '0;
				n_wd.box = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN};
			end
			S_CLB_PAR: n_ra = par;
			S_CLB_UPD: begin
				n_we = '{lt_q, !lt_q, lt_q, !lt_q, 1'b0, 1'b1, 1'b1};
				n_wa = par_q;
				n_wd.first = s_q;
				n_wd.last = e_q;
				n_wd.left = node_q;
				n_wd.right = node_q;
				n_wd.visited = 1'b1;
				n_wd.box = merged;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			built_q <= '0;
			root_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && action == ACT_READ) begin
						rd_idx_q <= node_to_read;
						state_q <= S_READ;
					end else if (accept) begin
						if (final_primitive) begin
							n_q <= (count_q < 11'(MAX_PRIM)) ? count_q + 11'd1 : count_q;
							count_q <= '0;
							i_q <= 11'd1;
							state_q <= S_SORT_FETCH;
						end else if (count_q < 11'(MAX_PRIM)) begin
							count_q <= count_q + 11'd1;
						end
					end
				end
				S_READ: begin
					if (built_q != '0 && {1'b0, rd_idx_q} < built_nodes) begin
						out_q <= node_rd;
						leaf_out_q <= (rd_idx_q < built_q) ? {1'b0, node_rd.leaf} : NOT_LEAF;
					end else begin
						out_q <= '{'0, '0, NO_CHILD, NO_CHILD, '0, 1'b0, '0};
						leaf_out_q <= NOT_LEAF;
					end
					root_out_q <= root_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SORT_FETCH: begin
					if (i_q >= n_q) begin
						i_q <= '0;
						state_q <= S_DLT_RD;
					end else begin
						state_q <= S_SORT_KEY;
					end
				end
				S_SORT_KEY: begin
					k_q <= key_rd;
					j_q <= i_q;
					state_q <= S_SORT_CMP;
				end
				S_SORT_CMP: begin
					if (key_rd > k_q) begin
						j_q <= j_q - 11'd1;
						if (j_q == 11'd1) state_q <= S_SORT_PLACE;
					end else begin
						i_q <= i_q + 11'd1;
						state_q <= S_SORT_FETCH;
					end
				end
				S_SORT_PLACE: begin
					i_q <= i_q + 11'd1;
					state_q <= S_SORT_FETCH;
				end
				S_DLT_RD: state_q <= S_DLT_X;
				S_DLT_X: begin
					kd_q <= key_rd;
					state_q <= S_DLT_WR;
				end
				S_DLT_WR: begin
					prev_q <= kd_q;
					i_q <= i_q + 11'd1;
					state_q <= (i_q == n_q - 11'd1) ? S_DLT_END : S_DLT_RD;
				end
				S_DLT_END: begin
					i_q <= n_q;
					built_q <= n_q;
					root_q <= '0;
					state_q <= S_INIT;
				end
				S_INIT: begin
					if ({1'b0, i_q} < node_count) begin
						i_q <= i_q + 11'd1;
					end else begin
						i_q <= '0;
						state_q <= (n_q == 11'd1) ? S_IDLE : S_CLB_LEAF;
					end
				end
				S_CLB_LEAF: begin
					if (i_q == n_q) begin
						state_q <= S_IDLE;
					end else begin
						node_q <= i_q;
						s_q <= i_q[PRIM_W-1:0];
						e_q <= i_q[PRIM_W-1:0];
						state_q <= S_CLB_BOX;
					end
				end
				S_CLB_BOX: begin
					box_q <= node_rd.box;
					state_q <= S_CLB_DRD;
				end
				S_CLB_DRD: state_q <= S_CLB_PAR;
				S_CLB_PAR: begin
					lt_q <= lt;
					par_q <= par;
					if (brk) begin
						i_q <= i_q + 11'd1;
						state_q <= S_CLB_LEAF;
					end else begin
						state_q <= S_CLB_UPD;
					end
				end
				S_CLB_UPD: begin
					if (!node_rd.visited) begin
						i_q <= i_q + 11'd1;
						state_q <= S_CLB_LEAF;
					end else if (new_first == '0 && {1'b0, new_last} == n_q - 11'd1) begin
						root_q <= par_q;
						i_q <= i_q + 11'd1;
						state_q <= S_CLB_LEAF;
					end else begin
						node_q <= par_q;
						s_q <= new_first;
						e_q <= new_last;
						box_q <= merged;
						state_q <= S_CLB_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign span_first = out_q.first;
	assign span_final = out_q.last;
	assign left_link = out_q.left;
	assign right_link = out_q.right;
	assign leaf_primitive = leaf_out_q;
	assign merged_min_x = out_q.box.min_x;
	assign merged_min_y = out_q.box.min_y;
	assign merged_min_z = out_q.box.min_z;
	assign merged_max_x = out_q.box.max_x;
	assign merged_max_y = out_q.box.max_y;
	assign merged_max_z = out_q.box.max_z;
	assign root_node = root_out_q;

`ifndef SYNTH
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a word is pending");
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_READ))
		else $error("result word without a read");
	a_built_cap: assert property (@(posedge clk) disable iff (!arst_n)
		built_q <= 11'(MAX_PRIM))
		else $error("built count beyond capacity");
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLB_DRD |-> s_q <= e_q)
		else $error("climb range inverted");
`endif

endmodule

### rtl/lbvh_node_mem.sv
module lbvh_node_mem (
	input  logic               clk,
	input  lbvh_pkg::node_we_t we,
	input  lbvh_pkg::node_idx_t waddr,
	input  lbvh_pkg::node_t    wdata,
	input  lbvh_pkg::node_idx_t raddr,
	output lbvh_pkg::node_t    rdata
);
	import lbvh_pkg::*;

	prim_idx_t first_mem [NODE_DEPTH];
	prim_idx_t last_mem  [NODE_DEPTH];
	node_idx_t left_mem  [NODE_DEPTH];
	node_idx_t right_mem [NODE_DEPTH];
	prim_idx_t leaf_mem  [MAX_PRIM];
	logic      vis_mem   [NODE_DEPTH];
	box_t      box_mem   [NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (we.first) first_mem[waddr] <= wdata.first;
		if (we.last) last_mem[waddr] <= wdata.last;
		if (we.left) left_mem[waddr] <= wdata.left;
		if (we.right) right_mem[waddr] <= wdata.right;
		if (we.leaf) leaf_mem[waddr[PRIM_W-1:0]] <= wdata.leaf;
		if (we.visited) vis_mem[waddr] <= wdata.visited;
		if (we.box) box_mem[waddr] <= wdata.box;
		rdata.first   <= first_mem[raddr];
		rdata.last    <= last_mem[raddr];
		rdata.left    <= left_mem[raddr];
		rdata.right   <= right_mem[raddr];
		rdata.leaf    <= leaf_mem[raddr[PRIM_W-1:0]];
		rdata.visited <= vis_mem[raddr];
		rdata.box     <= box_mem[raddr];
	end

endmodule

### rtl/lbvh_delta_unit.sv
module lbvh_delta_unit (
	input  logic               clk,
	input  lbvh_pkg::key_t     diff,
	output lbvh_pkg::delta_t   delta_s1
);
	import lbvh_pkg::*;

	logic [MORTON_W-1:0] hi;
	logic [PRIM_W-1:0]   lo;
	logic [5:0]          hz;
	logic [3:0]          lz;
	delta_t              delta;

	always_comb begin
		hi = diff[KEY_W-1:PRIM_W];
		lo = diff[PRIM_W-1:0];
		hz = 6'd32;
		for (int b = 0; b < MORTON_W; b++) begin
			if (hi[b]) hz = 6'(MORTON_W - 1 - b);
		end
		lz = 4'd10;
		for (int b = 0; b < PRIM_W; b++) begin
			if (lo[b]) lz = 4'(PRIM_W - 1 - b);
		end
		if (hi != '0) begin
			delta = delta_t'({2'b00, hz});
		end else if (lo != '0) begin
			delta = 8'sd54 + delta_t'({4'd0, lz});
		end else begin
			delta = DELTA_EQUAL;
		end
	end

	always_ff @(posedge clk) begin
		delta_s1 <= delta;
	end

endmodule
